// ===== rtl/core/uniaxial_plasticity_return_map_assert.svh =====
`ifndef UNIAXIAL_PLASTICITY_RETURN_MAP_ASSERT_SVH
`define UNIAXIAL_PLASTICITY_RETURN_MAP_ASSERT_SVH

// same-cycle implication
`define UPR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/upr_pkg.sv =====
package upr_pkg;

    localparam int MOD_W   = 47;
    localparam int MUL_W   = 50;
    localparam int DEN_W   = 50;
    localparam int QUO_W   = 47;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_ELASTIC   = 3'd0;
    localparam logic [IDX_W-1:0] REG_YIELD     = 3'd1;
    localparam logic [IDX_W-1:0] REG_ISOTROPIC = 3'd2;
    localparam logic [IDX_W-1:0] REG_KINEMATIC = 3'd3;
    localparam logic [IDX_W-1:0] REG_VISCOUS   = 3'd4;

    typedef enum logic [1:0] {
        OP_TRIAL  = 2'd0,
        OP_COMMIT = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_M1,
        S_X,
        S_F,
        S_G,
        S_GW,
        S_CW,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] total_strain;
    } in_t;

    typedef struct packed {
        logic signed [47:0] trial_stress;
        logic [46:0]        trial_tangent;
        logic               yielding;
    } out_t;

    function automatic logic signed [47:0] sat48(input logic signed [52:0] v);
        if (v[52:47] == {6{v[47]}}) begin
            return v[47:0];
        end else if (v[52]) begin
            return {1'b1, 47'b0};
        end else begin
            return {1'b0, {47{1'b1}}};
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v[33:31] == {3{v[31]}}) begin
            return v[31:0];
        end else if (v[33]) begin
            return {1'b1, 31'b0};
        end else begin
            return {1'b0, {31{1'b1}}};
        end
    endfunction

endpackage

// ===== rtl/core/upr_serial_mul.sv =====
module upr_serial_mul #(
    parameter int W = upr_pkg::MUL_W
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic           busy,
    output logic [2*W-1:0] product
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  acc_reg;
    logic [W-1:0]  lo_reg;
    logic [W-1:0]  a_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [W:0]    sum;

    // one multiplier bit per cycle, lsb first
    assign sum = {1'b0, acc_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (!busy_reg) begin
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
                acc_reg  <= '0;
                lo_reg   <= b;
                a_reg    <= a;
            end
        end else begin
            acc_reg <= sum[W:1];
            lo_reg  <= {sum[0], lo_reg[W-1:1]};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy    = busy_reg;
    assign product = {acc_reg, lo_reg};

endmodule

// ===== rtl/core/upr_serial_div.sv =====
module upr_serial_div #(
    parameter int DW = upr_pkg::DEN_W,
    parameter int QW = upr_pkg::QUO_W
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [DW-1:0]            rem_init,
    input  logic [QW-1:0]            dvd_lo,
    input  logic [$clog2(QW+1)-1:0]  steps,
    input  logic [DW-1:0]            den,
    output logic                     busy,
    output logic [QW-1:0]            quotient
);

    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0] r_reg;
    logic [QW-1:0] sh_reg;
    logic [QW-1:0] q_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [DW:0]   t;
    logic [DW+1:0] sub;
    logic          ge;

    // restoring division, one quotient bit per cycle
    assign t   = {r_reg, sh_reg[QW-1]};
    assign sub = {1'b0, t} - {2'b0, den_reg};
    assign ge  = !sub[DW+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (!busy_reg) begin
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
                r_reg    <= rem_init;
                sh_reg   <= dvd_lo;
                den_reg  <= den;
                q_reg    <= '0;
            end
        end else begin
            r_reg   <= ge ? sub[DW-1:0] : t[DW-1:0];
            sh_reg  <= {sh_reg[QW-2:0], 1'b0};
            q_reg   <= {q_reg[QW-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

// ===== rtl/core/uniaxial_plasticity_return_map.sv =====
// commit, reset-to-start, unused op and repeated strain go straight to the result state; an
// elastic trial step first runs the multipliers, and a plastic one then also the divider.
// one transaction at a time: the next is taken when the result is issued, and the pace is
// set by the bit-serial multipliers and the divider of a plastic step.
// reset (aresetn low, synchronous) clears the state, configuration, history and the tangent.
module uniaxial_plasticity_return_map (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [upr_pkg::IDX_W-1:0]       cfg_index,
    input  logic [upr_pkg::MOD_W-1:0]       cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  upr_pkg::in_t                    s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output upr_pkg::out_t                   m_data
);

`include "uniaxial_plasticity_return_map_assert.svh"

    localparam int MW = upr_pkg::MUL_W;
    localparam int DW = upr_pkg::DEN_W;
    localparam int QW = upr_pkg::QUO_W;

    upr_pkg::state_t state_reg, state_next;

    logic [46:0] e_reg, sy_reg, hiso_reg, hkin_reg, eta_reg;

    logic signed [31:0] cps_reg, tps_reg, tts_reg;
    logic signed [47:0] cbs_reg, tbs_reg, ts_reg;
    logic [31:0]        chard_reg, thard_reg;
    logic [46:0]        tt_reg;
    logic               flag_reg;

    logic signed [47:0] sw_reg;
    logic [49:0]        radius_reg, den_reg, hsum_reg;
    logic               dneg_reg, neg_reg, gsat_reg;
    logic [48:0]        xmag_reg, f_reg;
    logic [31:0]        gamma_reg;

    logic          m_valid_reg, m_valid_next;
    upr_pkg::out_t m_data_reg;

    logic          accept;
    logic signed [32:0] diff;
    logic [32:0]   dmag;
    logic          same;

    logic              mula_start, mulb_start, div_start;
    logic [MW-1:0]     mulb_a, mulb_b, mula_b;
    logic [2*MW-1:0]   prod_a, prod_b;
    logic              mula_busy, mulb_busy, div_busy;
    logic [DW-1:0]     div_rem;
    logic [QW-1:0]     div_lo, quot;
    logic [$clog2(QW+1)-1:0] div_steps;

    logic [50:0]        mag1, mag3, mag4;
    logic signed [52:0] st1, st3, bs3;
    logic signed [48:0] xsi;
    logic signed [50:0] f;
    logic               elastic;
    logic               gsat;
    logic [31:0]        gamma_w;
    logic signed [33:0] ps3;
    logic [32:0]        hd3;
    logic               units_idle;

    assign accept = s_valid && s_ready;
    assign diff   = $signed({s_data.total_strain[31], s_data.total_strain})
                  - $signed({cps_reg[31], cps_reg});
    assign dmag   = diff[32] ? 33'(-diff) : 33'(diff);
    assign same   = (s_data.total_strain == tts_reg);

    assign units_idle = !mula_busy && !mulb_busy && !div_busy;

    assign mag1 = prod_a[80:30];
    assign st1  = dneg_reg ? -$signed({2'b0, mag1}) : $signed({2'b0, mag1});
    assign xsi  = $signed({sw_reg[47], sw_reg}) - $signed({cbs_reg[47], cbs_reg});
    assign f    = $signed({2'b0, xmag_reg}) - $signed({1'b0, radius_reg});
    assign elastic = f[50] || ((f == '0) && (e_reg == '0));
    assign gsat = (den_reg == '0) || ({3'b0, f_reg} >= {den_reg, 2'b00});
    assign gamma_w = gsat_reg ? 32'hFFFF_FFFF : quot[31:0];

    assign mag3 = prod_a[80:30];
    assign mag4 = prod_b[80:30];
    assign st3  = neg_reg ? $signed({{5{sw_reg[47]}}, sw_reg}) + $signed({2'b0, mag3})
                          : $signed({{5{sw_reg[47]}}, sw_reg}) - $signed({2'b0, mag3});
    assign bs3  = neg_reg ? $signed({{5{cbs_reg[47]}}, cbs_reg}) - $signed({2'b0, mag4})
                          : $signed({{5{cbs_reg[47]}}, cbs_reg}) + $signed({2'b0, mag4});
    assign ps3  = neg_reg ? $signed({{2{cps_reg[31]}}, cps_reg}) - $signed({2'b0, gamma_reg})
                          : $signed({{2{cps_reg[31]}}, cps_reg}) + $signed({2'b0, gamma_reg});
    assign hd3  = {1'b0, chard_reg} + {1'b0, gamma_reg};

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = (state_reg == upr_pkg::S_IDLE);
        mula_start   = 1'b0;
        mulb_start   = 1'b0;
        div_start    = 1'b0;
        mula_b       = {17'b0, dmag};
        mulb_a       = {3'b0, hiso_reg};
        mulb_b       = {18'b0, chard_reg};
        div_rem      = {3'b0, f_reg[48:2]};
        div_lo       = {f_reg[1:0], 45'b0};
        div_steps    = ($clog2(QW+1))'(32);
        unique case (state_reg)
            upr_pkg::S_IDLE: begin
                if (accept) begin
                    if (s_data.op == upr_pkg::OP_TRIAL && !same) begin
                        mula_start = 1'b1;
                        mulb_start = 1'b1;
                        state_next = upr_pkg::S_M1;
                    end else begin
                        state_next = upr_pkg::S_DONE;
                    end
                end
            end
            upr_pkg::S_M1: begin
                if (units_idle) begin
                    state_next = upr_pkg::S_X;
                end
            end
            upr_pkg::S_X: begin
                state_next = upr_pkg::S_F;
            end
            upr_pkg::S_F: begin
                state_next = elastic ? upr_pkg::S_DONE : upr_pkg::S_G;
            end
            upr_pkg::S_G: begin
                mulb_a     = {3'b0, e_reg};
                mulb_b     = hsum_reg;
                mulb_start = 1'b1;
                div_start  = !gsat;
                state_next = upr_pkg::S_GW;
            end
            upr_pkg::S_GW: begin
                mula_b    = {18'b0, gamma_w};
                mulb_a    = {3'b0, hkin_reg};
                mulb_b    = {18'b0, gamma_w};
                div_rem   = {1'b0, prod_b[95:47]};
                div_lo    = prod_b[46:0];
                div_steps = ($clog2(QW+1))'(QW);
                if (units_idle) begin
                    mula_start = 1'b1;
                    mulb_start = 1'b1;
                    div_start  = 1'b1;
                    state_next = upr_pkg::S_CW;
                end
            end
            upr_pkg::S_CW: begin
                if (units_idle) begin
                    state_next = upr_pkg::S_DONE;
                end
            end
            upr_pkg::S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = upr_pkg::S_IDLE;
                end
            end
            default: state_next = upr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= upr_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == upr_pkg::S_DONE && (!m_valid_reg || m_ready)) begin
            m_data_reg <= '{trial_stress: ts_reg, trial_tangent: tt_reg, yielding: flag_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_reg     <= '0;
            sy_reg    <= '0;
            hiso_reg  <= '0;
            hkin_reg  <= '0;
            eta_reg   <= '0;
            cps_reg   <= '0;
            cbs_reg   <= '0;
            chard_reg <= '0;
            tps_reg   <= '0;
            tbs_reg   <= '0;
            thard_reg <= '0;
            tts_reg   <= '0;
            ts_reg    <= '0;
            tt_reg    <= '0;
            flag_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    upr_pkg::REG_ELASTIC:   e_reg    <= cfg_wr_data;
                    upr_pkg::REG_YIELD:     sy_reg   <= cfg_wr_data;
                    upr_pkg::REG_ISOTROPIC: hiso_reg <= cfg_wr_data;
                    upr_pkg::REG_KINEMATIC: hkin_reg <= cfg_wr_data;
                    upr_pkg::REG_VISCOUS:   eta_reg  <= cfg_wr_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                upr_pkg::S_IDLE: begin
                    if (accept) begin
                        unique case (s_data.op)
                            upr_pkg::OP_TRIAL: begin
                                if (!same) begin
                                    tts_reg  <= s_data.total_strain;
                                    dneg_reg <= diff[32];
                                end
                            end
                            upr_pkg::OP_COMMIT: begin
                                cps_reg   <= tps_reg;
                                cbs_reg   <= tbs_reg;
                                chard_reg <= thard_reg;
                            end
                            upr_pkg::OP_CLEAR: begin
                                cps_reg   <= '0;
                                cbs_reg   <= '0;
                                chard_reg <= '0;
                                tps_reg   <= '0;
                                tbs_reg   <= '0;
                                thard_reg <= '0;
                                tts_reg   <= '0;
                                ts_reg    <= '0;
                                tt_reg    <= e_reg;
                                flag_reg  <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                upr_pkg::S_M1: begin
                    if (units_idle) begin
                        sw_reg     <= upr_pkg::sat48(st1);
                        radius_reg <= {3'b0, sy_reg} + mag4[49:0];
                        hsum_reg   <= {3'b0, hiso_reg} + {3'b0, hkin_reg} + {3'b0, eta_reg};
                        den_reg    <= {3'b0, e_reg} + {3'b0, hiso_reg}
                                    + {3'b0, hkin_reg} + {3'b0, eta_reg};
                    end
                end
                upr_pkg::S_X: begin
                    neg_reg  <= xsi[48];
                    xmag_reg <= xsi[48] ? 49'(-xsi) : 49'(xsi);
                end
                upr_pkg::S_F: begin
                    f_reg <= f[48:0];
                    if (elastic) begin
                        ts_reg    <= sw_reg;
                        tt_reg    <= e_reg;
                        tps_reg   <= cps_reg;
                        tbs_reg   <= cbs_reg;
                        thard_reg <= chard_reg;
                        flag_reg  <= 1'b0;
                    end
                end
                upr_pkg::S_G: begin
                    gsat_reg <= gsat;
                end
                upr_pkg::S_GW: begin
                    if (units_idle) begin
                        gamma_reg <= gamma_w;
                    end
                end
                upr_pkg::S_CW: begin
                    if (units_idle) begin
                        ts_reg    <= upr_pkg::sat48(st3);
                        tbs_reg   <= upr_pkg::sat48(bs3);
                        tps_reg   <= upr_pkg::sat32(ps3);
                        thard_reg <= hd3[32] ? 32'hFFFF_FFFF : hd3[31:0];
                        tt_reg    <= (den_reg == '0) ? '0 : quot;
                        flag_reg  <= 1'b1;
                    end
                end
                upr_pkg::S_DONE: ;
                default: ;
            endcase
        end
    end

    upr_serial_mul #(.W(MW)) u_mul_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mula_start),
        .a       ({3'b0, e_reg}),
        .b       (mula_b),
        .busy    (mula_busy),
        .product (prod_a)
    );

    upr_serial_mul #(.W(MW)) u_mul_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mulb_start),
        .a       (mulb_a),
        .b       (mulb_b),
        .busy    (mulb_busy),
        .product (prod_b)
    );

    upr_serial_div #(.DW(DW), .QW(QW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init (div_rem),
        .dvd_lo   (div_lo),
        .steps    (div_steps),
        .den      (den_reg),
        .busy     (div_busy),
        .quotient (quot)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `UPR_ASSERT_NOW(a_idle_units, aclk, aresetn, state_reg == upr_pkg::S_IDLE,
        units_idle, "arithmetic unit busy while idle")
    `UPR_ASSERT_NEXT(a_commit_done, aclk, aresetn,
        accept && s_data.op == upr_pkg::OP_COMMIT,
        state_reg == upr_pkg::S_DONE, "commit did not go straight to result")
    `UPR_ASSERT_NOW(a_hardening_grows, aclk, aresetn, flag_reg,
        thard_reg >= chard_reg, "trial hardening below committed in plastic state")

endmodule
